>>> rtl/snmr_pkg.sv
`timescale 1ns / 1ps
package snmr_pkg;
    localparam int SW = 24;
    localparam int CPS = 12;
    localparam int RFRAC = 24;
    localparam int NW = 51;
    localparam int VW = 52;
    localparam int TW = 63;
    localparam int QB = NW + RFRAC;
    localparam int CW = $clog2(QB + 1);
    localparam logic [NW-1:0] NORM_MAX = '1;
    localparam logic [VW-1:0] VAL_MAX = '1;
    localparam logic [TW-1:0] SUM_MAX = '1;

    typedef enum logic [2:0] {
        ST_IDLE, ST_SQ, ST_ACC, ST_CDIV, ST_CUPD, ST_SDIV, ST_SUPD, ST_OUT
    } state_t;

    typedef struct packed {
        logic load;
        logic sq;
        logic acc;
        logic cdiv_start;
        logic cupd;
        logic sdiv_start;
        logic supd;
        logic clear;
    } cmd_t;

    typedef struct packed {
        logic div_busy;
        logic rel;
        logic pcm;
        logic last;
        logic eov;
    } sts_t;
endpackage

>>> rtl/squared_norm_min_max_reduce.sv
// The result follows the closing transaction through the square, accumulate,
// component-update and site-update states, waiting out a ratio divide before each
// update that uses one (site: relative mode; component: also per-component mode).
// Components are taken only when idle; a vector end also waits for the result transaction.
// Reset: rst_n asynchronous active low clears all accumulators and the FSM.
`timescale 1ns / 1ps
module squared_norm_min_max_reduce (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_we,
    input  logic         cfg_index,
    input  logic         cfg_data,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [95:0]  s_tdata,  // sig_re, sig_im, ref_re, ref_im
    input  logic         s_tlast,  // end_of_vector
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [271:0] m_tdata,  // total_sum, site_min, site_max, component_min,
                                   // component_max
    output logic         m_tuser   // ratio_overflow
);
    import snmr_pkg::*;

    logic rel_reg, pcm_reg;
    cmd_t cmd;
    sts_t sts;
    logic [TW-1:0] tsum;
    logic [VW-1:0] smin, smax, cmin, cmax;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rel_reg <= 1'b0;
            pcm_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            if (cfg_index == 1'b0) rel_reg <= cfg_data;
            else pcm_reg <= cfg_data;
        end
    end

    snmr_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .in_fire(s_tvalid && s_tready),
        .out_fire(m_tvalid && m_tready), .sts(sts), .cmd(cmd),
        .in_rdy(s_tready), .out_vld(m_tvalid)
    );

    snmr_dp u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts),
        .relative_mode(rel_reg), .per_component_mode(pcm_reg),
        .sig_re(s_tdata[23:0]), .sig_im(s_tdata[47:24]),
        .ref_re(s_tdata[71:48]), .ref_im(s_tdata[95:72]), .eov_in(s_tlast),
        .total_sum(tsum), .site_min(smin), .site_max(smax),
        .component_min(cmin), .component_max(cmax), .ratio_overflow(m_tuser)
    );

    assign m_tdata = {1'b0, cmax, cmin, smax, smin, tsum};
endmodule

>>> rtl/snmr_div.sv
`timescale 1ns / 1ps
module snmr_div (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [snmr_pkg::NW-1:0]    num,
    input  logic [snmr_pkg::NW-1:0]    den,
    output logic                       busy,
    output logic [snmr_pkg::VW-1:0]    quo,
    output logic                       ovf
);
    import snmr_pkg::*;

    logic [CW-1:0]   cnt_reg, cnt_next;
    logic [QB-1:0]   n_reg, n_next;
    logic [NW:0]     r_reg, r_next;
    logic [QB-1:0]   q_reg, q_next;
    logic [NW-1:0]   d_reg, d_next;
    logic [NW+1:0]   trial;

    assign busy = cnt_reg != '0;

    always_comb
    begin
        n_next = n_reg;
        r_next = r_reg;
        q_next = q_reg;
        d_next = d_reg;
        cnt_next = cnt_reg;
        trial = {r_reg, n_reg[QB-1]} - {2'b0, d_reg};
        if (start)
        begin
            n_next = {num, {RFRAC{1'b0}}};
            r_next = '0;
            q_next = '0;
            d_next = den;
            cnt_next = CW'(QB);
        end
        else if (busy)
        begin
            n_next = n_reg << 1;
            q_next = q_reg << 1;
            if (!trial[NW+1])
            begin
                r_next = trial[NW:0];
                q_next[0] = 1'b1;
            end
            else
            begin
                r_next = {r_reg[NW-1:0], n_reg[QB-1]};
            end
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= '0;
        else
            cnt_reg <= cnt_next;
    end

    always_ff @(posedge clk)
    begin
        n_reg <= n_next;
        r_reg <= r_next;
        q_reg <= q_next;
        d_reg <= d_next;
    end

    always_comb
    begin
        ovf = (d_reg == '0) || (q_reg[QB-1:VW] != '0);
        quo = ovf ? VAL_MAX : q_reg[VW-1:0];
    end
endmodule

>>> rtl/snmr_ctrl.sv
`timescale 1ns / 1ps
module snmr_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_fire,
    input  logic            out_fire,
    input  snmr_pkg::sts_t  sts,
    output snmr_pkg::cmd_t  cmd,
    output logic            in_rdy,
    output logic            out_vld
);
    import snmr_pkg::*;

    state_t st_reg, st_next;

    always_comb
    begin
        st_next = st_reg;
        unique case (st_reg)
            ST_IDLE: if (in_fire) st_next = ST_SQ;
            ST_SQ:   st_next = ST_ACC;
            ST_ACC:  st_next = (sts.pcm && sts.rel) ? ST_CDIV : ST_CUPD;
            ST_CDIV: if (!sts.div_busy) st_next = ST_CUPD;
            ST_CUPD:
                if (sts.last && sts.rel) st_next = ST_SDIV;
                else if (sts.last) st_next = ST_SUPD;
                else st_next = ST_IDLE;
            ST_SDIV: if (!sts.div_busy) st_next = ST_SUPD;
            ST_SUPD: st_next = sts.eov ? ST_OUT : ST_IDLE;
            ST_OUT:  if (out_fire) st_next = ST_IDLE;
            default: st_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd = '0;
        in_rdy = 1'b0;
        out_vld = 1'b0;
        unique case (st_reg)
            ST_IDLE: begin in_rdy = 1'b1; cmd.load = in_fire; end
            ST_SQ:   cmd.sq = 1'b1;
            ST_ACC:
            begin
                cmd.acc = 1'b1;
                cmd.cdiv_start = sts.pcm && sts.rel;
            end
            ST_CDIV: ;
            ST_CUPD: begin cmd.cupd = 1'b1; cmd.sdiv_start = sts.last && sts.rel; end
            ST_SDIV: ;
            ST_SUPD: cmd.supd = 1'b1;
            ST_OUT:  begin out_vld = 1'b1; cmd.clear = out_fire; end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            st_reg <= ST_IDLE;
        else
            st_reg <= st_next;
    end

    a_rdy_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in_rdy |-> !out_vld) else $error("ready while result pending");
    a_div_wait: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.cdiv_start |=> st_reg == ST_CDIV) else $error("divide not awaited");
    a_clear: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.clear |=> st_reg == ST_IDLE) else $error("no return after output");
endmodule

>>> rtl/snmr_dp.sv
`timescale 1ns / 1ps
module snmr_dp (
    input  logic                  clk,
    input  logic                  rst_n,
    input  snmr_pkg::cmd_t        cmd,
    output snmr_pkg::sts_t        sts,
    input  logic                  relative_mode,
    input  logic                  per_component_mode,
    input  logic [snmr_pkg::SW-1:0] sig_re,
    input  logic [snmr_pkg::SW-1:0] sig_im,
    input  logic [snmr_pkg::SW-1:0] ref_re,
    input  logic [snmr_pkg::SW-1:0] ref_im,
    input  logic                  eov_in,
    output logic [snmr_pkg::TW-1:0] total_sum,
    output logic [snmr_pkg::VW-1:0] site_min,
    output logic [snmr_pkg::VW-1:0] site_max,
    output logic [snmr_pkg::VW-1:0] component_min,
    output logic [snmr_pkg::VW-1:0] component_max,
    output logic                  ratio_overflow
);
    import snmr_pkg::*;

    localparam int MW = 2 * SW + 1;

    logic [SW-1:0] a_reg [4];
    logic          eov_reg;
    logic          rel_reg;
    logic          pcm_reg;
    logic [MW-1:0] s_reg, r_reg;
    logic [NW-1:0] sn_reg, rn_reg;
    logic [TW-1:0] sum_reg;
    logic [VW-1:0] smin_reg, smax_reg, cmin_reg, cmax_reg;
    logic          smin_seen_reg, cmin_seen_reg, ovf_reg;
    logic [3:0]    idx_reg;
    logic          last_reg;

    logic          dstart, dbusy, dovf;
    logic [NW-1:0] dnum, dden;
    logic [VW-1:0] dquo;
    logic [SW-1:0] m [4];
    logic [NW:0]   sn_add, rn_add;
    logic [NW-1:0] sn_sat, rn_sat;
    logic [VW-1:0] cval, sval;
    logic [TW:0]   sum_add;

    always_comb
    begin
        for (int i = 0; i < 4; i++)
            m[i] = a_reg[i][SW-1] ? SW'(-a_reg[i]) : a_reg[i];
        sn_add = {1'b0, sn_reg} + (NW+1)'(s_reg);
        rn_add = {1'b0, rn_reg} + (NW+1)'(r_reg);
        sn_sat = (sn_add > (NW+1)'(NORM_MAX)) ? NORM_MAX : sn_add[NW-1:0];
        rn_sat = (rn_add > (NW+1)'(NORM_MAX)) ? NORM_MAX : rn_add[NW-1:0];
        cval = rel_reg ? dquo : VW'(s_reg);
        sval = rel_reg ? dquo : VW'(sn_reg);
        sum_add = {1'b0, sum_reg} + (TW+1)'(sval);
        dstart = cmd.cdiv_start || cmd.sdiv_start;
        dnum = cmd.cdiv_start ? NW'(s_reg) : sn_reg;
        dden = cmd.cdiv_start ? NW'(r_reg) : rn_reg;
    end

    snmr_div u_div (
        .clk(clk), .rst_n(rst_n), .start(dstart), .num(dnum), .den(dden),
        .busy(dbusy), .quo(dquo), .ovf(dovf)
    );

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            a_reg[0] <= sig_re;
            a_reg[1] <= sig_im;
            a_reg[2] <= ref_re;
            a_reg[3] <= ref_im;
            eov_reg <= eov_in;
            rel_reg <= relative_mode;
            pcm_reg <= per_component_mode;
        end
        if (cmd.sq)
        begin
            s_reg <= MW'(m[0] * m[0]) + MW'(m[1] * m[1]);
            r_reg <= MW'(m[2] * m[2]) + MW'(m[3] * m[3]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sn_reg <= '0; rn_reg <= '0; sum_reg <= '0;
            smin_reg <= '0; smax_reg <= '0; cmin_reg <= '0; cmax_reg <= '0;
            smin_seen_reg <= 1'b0; cmin_seen_reg <= 1'b0; ovf_reg <= 1'b0;
            idx_reg <= '0; last_reg <= 1'b0;
        end
        else
        begin
            if (cmd.acc)
            begin
                sn_reg <= sn_sat;
                rn_reg <= rn_sat;
                last_reg <= eov_reg || (idx_reg >= 4'(CPS - 1));
            end
            if (cmd.cupd)
            begin
                if (pcm_reg)
                begin
                    if (cval > cmax_reg) cmax_reg <= cval;
                    if (!cmin_seen_reg || cval < cmin_reg) cmin_reg <= cval;
                    cmin_seen_reg <= 1'b1;
                    if (rel_reg && dovf) ovf_reg <= 1'b1;
                end
                idx_reg <= last_reg ? 4'd0 : idx_reg + 4'd1;
            end
            if (cmd.supd)
            begin
                sum_reg <= sum_add[TW] ? SUM_MAX : sum_add[TW-1:0];
                if (sval > smax_reg) smax_reg <= sval;
                if (!smin_seen_reg || sval < smin_reg) smin_reg <= sval;
                smin_seen_reg <= 1'b1;
                if (rel_reg && dovf) ovf_reg <= 1'b1;
                sn_reg <= '0;
                rn_reg <= '0;
            end
            if (cmd.clear)
            begin
                sum_reg <= '0; smin_reg <= '0; smax_reg <= '0;
                cmin_reg <= '0; cmax_reg <= '0;
                smin_seen_reg <= 1'b0; cmin_seen_reg <= 1'b0; ovf_reg <= 1'b0;
            end
        end
    end

    assign sts = '{div_busy: dbusy, rel: rel_reg, pcm: pcm_reg,
                   last: last_reg, eov: eov_reg};
    assign total_sum = sum_reg;
    assign site_min = smin_reg;
    assign site_max = smax_reg;
    assign component_min = cmin_reg;
    assign component_max = cmax_reg;
    assign ratio_overflow = ovf_reg;

    a_minmax: assert property (@(posedge clk) disable iff (!rst_n)
        smin_seen_reg |-> smin_reg <= smax_reg) else $error("site min above max");
    a_idx: assert property (@(posedge clk) disable iff (!rst_n)
        idx_reg < 4'(CPS)) else $error("index out of range");
    a_div: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.cupd || cmd.supd) && rel_reg && (cmd.supd || pcm_reg) |-> !dbusy)
        else $error("divide result used while busy");
endmodule

>>> tb/sv/tb.sv
`timescale 1ns / 1ps
module tb;
    import snmr_pkg::*;

    localparam longint unsigned LIMIT = 3000000;
    localparam int SETTLE = 400;
    localparam longint unsigned QMAX = VAL_MAX >> RFRAC;

    typedef enum logic {
        REG_RELATIVE = 1'b0,
        REG_PER_COMPONENT = 1'b1
    } reg_index_t;

    typedef struct packed {
        logic [TW-1:0] total;
        logic [VW-1:0] smin;
        logic [VW-1:0] smax;
        logic [VW-1:0] cmin;
        logic [VW-1:0] cmax;
        logic          ovf;
    } norm_result_t;

    logic         clk;
    logic         rst_n;
    logic         cfg_we;
    logic         cfg_index;
    logic         cfg_data;
    logic         s_tvalid;
    logic         s_tready;
    logic [95:0]  s_tdata;  // sig_re, sig_im, ref_re, ref_im
    logic         s_tlast;  // end_of_vector
    logic         m_tvalid;
    logic         m_tready;
    logic [271:0] m_tdata;  // total_sum, site_min, site_max, component_min, component_max
    logic         m_tuser;  // ratio_overflow

    squared_norm_min_max_reduce dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    // predictor state
    logic            p_rel;
    logic            p_pcm;
    longint unsigned p_sum;
    longint unsigned p_sig_norm;
    longint unsigned p_ref_norm;
    longint unsigned p_smin;
    longint unsigned p_smax;
    logic            p_smin_seen;
    longint unsigned p_cmin;
    longint unsigned p_cmax;
    logic            p_cmin_seen;
    int unsigned     p_idx;
    logic            p_ovf;

    norm_result_t    expected_q[$];
    int              errors;
    longint unsigned cycles;
    int              send_gap;
    bit              src_idle_en;
    bit              snk_idle_en;
    int              stall_left;

    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > LIMIT)
        begin
            $display("tb: errors");
            $finish;
        end
    end

    function automatic longint unsigned mag_sq(logic [23:0] re, logic [23:0] im);
        longint unsigned a;
        longint unsigned b;
        a = re[23] ? longint'(24'(-re)) : longint'(re);
        b = im[23] ? longint'(24'(-im)) : longint'(im);
        return a * a + b * b;
    endfunction

    function automatic longint unsigned sat_add(longint unsigned a, longint unsigned b,
                                                 longint unsigned cap);
        if (a >= cap || b >= cap || b > cap - a)
            return cap;
        return a + b;
    endfunction

    function automatic longint unsigned divide_q24(longint unsigned num, longint unsigned den);
        longint unsigned q;
        longint unsigned rem;
        longint unsigned frac;
        frac = 0;
        if (den == 0)
        begin
            p_ovf = 1'b1;
            return VAL_MAX;
        end
        q = num / den;
        if (q > QMAX)
        begin
            p_ovf = 1'b1;
            return VAL_MAX;
        end
        rem = num % den;
        for (int i = 0; i < RFRAC; i++)
        begin
            rem = rem << 1;
            frac = frac << 1;
            if (rem >= den)
            begin
                rem = rem - den;
                frac = frac | 1;
            end
        end
        return (q << RFRAC) | frac;
    endfunction

    task automatic clear_accumulators();
        p_sum = 0;
        p_smin = 0;
        p_smax = 0;
        p_smin_seen = 1'b0;
        p_cmin = 0;
        p_cmax = 0;
        p_cmin_seen = 1'b0;
        p_ovf = 1'b0;
    endtask

    task automatic predict_component(logic [95:0] d, logic eov);
        longint unsigned s;
        longint unsigned r;
        longint unsigned v;
        longint unsigned site;
        norm_result_t res;
        s = mag_sq(d[23:0], d[47:24]);
        r = mag_sq(d[71:48], d[95:72]);
        p_sig_norm = sat_add(p_sig_norm, s, NORM_MAX);
        p_ref_norm = sat_add(p_ref_norm, r, NORM_MAX);
        if (p_pcm)
        begin
            v = p_rel ? divide_q24(s, r) : s;
            if (v > p_cmax)
                p_cmax = v;
            if (!p_cmin_seen || v < p_cmin)
                p_cmin = v;
            p_cmin_seen = 1'b1;
        end
        if (eov || p_idx >= CPS - 1)
        begin
            site = p_rel ? divide_q24(p_sig_norm, p_ref_norm) : p_sig_norm;
            p_sum = sat_add(p_sum, site, SUM_MAX);
            if (site > p_smax)
                p_smax = site;
            if (!p_smin_seen || site < p_smin)
                p_smin = site;
            p_smin_seen = 1'b1;
            p_sig_norm = 0;
            p_ref_norm = 0;
            p_idx = 0;
        end
        else
            p_idx = (p_idx + 1) & 15;
        if (eov)
        begin
            res.total = TW'(p_sum);
            res.smin = p_smin_seen ? VW'(p_smin) : '0;
            res.smax = VW'(p_smax);
            res.cmin = p_cmin_seen ? VW'(p_cmin) : '0;
            res.cmax = VW'(p_cmax);
            res.ovf = p_ovf;
            expected_q.push_back(res);
            clear_accumulators();
        end
    endtask

    task automatic report(string what, logic [63:0] got, logic [63:0] want);
        errors++;
        $display("tb: mismatch %s got %h want %h at cycle %0d", what, got, want, cycles);
    endtask

    // result sink: random stalls
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
            stall_left <= 0;
        end
        else if (m_tvalid && m_tready)
        begin
            stall_left <= snk_idle_en ? $urandom_range(0, 10) : 0;
            m_tready <= !snk_idle_en || ($urandom_range(0, 1) == 0);
        end
        else if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            m_tready <= 1'b0;
        end
        else
            m_tready <= 1'b1;
    end

    always @(posedge clk)
    begin
        norm_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_q.size() == 0)
            begin
                errors++;
                $display("tb: unexpected transaction at cycle %0d", cycles);
            end
            else
            begin
                want = expected_q.pop_front();
                if (m_tdata[62:0] !== want.total)
                    report("total_sum", 64'(m_tdata[62:0]), 64'(want.total));
                if (m_tdata[114:63] !== want.smin)
                    report("site_min", 64'(m_tdata[114:63]), 64'(want.smin));
                if (m_tdata[166:115] !== want.smax)
                    report("site_max", 64'(m_tdata[166:115]), 64'(want.smax));
                if (m_tdata[218:167] !== want.cmin)
                    report("component_min", 64'(m_tdata[218:167]), 64'(want.cmin));
                if (m_tdata[270:219] !== want.cmax)
                    report("component_max", 64'(m_tdata[270:219]), 64'(want.cmax));
                if (m_tuser !== want.ovf)
                    report("ratio_overflow", 64'(m_tuser), 64'(want.ovf));
            end
        end
    end

    task automatic send_component(logic [95:0] d, logic eov);
        if (send_gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (send_gap) @(posedge clk);
        end
        s_tdata <= d;
        s_tlast <= eov;
        s_tvalid <= 1'b1;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        predict_component(d, eov);
        send_gap = src_idle_en ? $urandom_range(0, 10) : 0;
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        send_gap = 0;
        while (expected_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic set_modes(logic rel, logic pcm);
        wait_idle();
        cfg_we <= 1'b1;
        cfg_index <= REG_RELATIVE;
        cfg_data <= rel;
        @(posedge clk);
        p_rel = rel;
        cfg_index <= REG_PER_COMPONENT;
        cfg_data <= pcm;
        @(posedge clk);
        p_pcm = pcm;
        cfg_we <= 1'b0;
    endtask

    function automatic logic [23:0] pick_sample();
        case ($urandom_range(0, 7))
            0: return 24'h800000;
            1: return 24'h7FFFFF;
            2: return 24'h000000;
            3: return 24'(int'($urandom_range(0, 15)) - 8);
            4: return 24'h800001;
            default: return 24'($urandom);
        endcase
    endfunction

    function automatic logic [95:0] pick_component();
        return {pick_sample(), pick_sample(), pick_sample(), pick_sample()};
    endfunction

    task automatic send_vector(int len);
        for (int i = 0; i < len; i++)
            send_component(pick_component(), i == len - 1);
    endtask

    task automatic test_plain_norms();
        set_modes(1'b0, 1'b0);
        send_component({24'h800000, 24'h800000, 24'h800000, 24'h800000}, 1'b1);
        send_component({24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF}, 1'b1);
        for (int i = 0; i < 13; i++)
            send_component({4{24'h800000}}, i == 12);
        send_vector(12);
        send_vector(5);
    endtask

    task automatic test_component_tracking();
        set_modes(1'b0, 1'b1);
        send_component({24'h0, 24'h0, 24'h000001, 24'h0}, 1'b0);
        send_component({24'h0, 24'h0, 24'h800000, 24'h7FFFFF}, 1'b0);
        send_component({24'h0, 24'h0, 24'hFFFFFF, 24'h000003}, 1'b1);
    endtask

    task automatic test_ratios();
        set_modes(1'b1, 1'b1);
        // zero over zero, and nonzero over zero
        send_component({96'h0}, 1'b1);
        send_component({24'h0, 24'h0, 24'h0, 24'h400000}, 1'b1);
        // tiny divisor saturates
        send_component({24'h000001, 24'h0, 24'h7FFFFF, 24'h800000}, 1'b1);
        send_component({24'h100000, 24'h0, 24'h0, 24'h100000}, 1'b1);
        set_modes(1'b1, 1'b0);
        send_vector(12);
        send_vector(3);
    endtask

    task automatic test_mode_change_mid_vector();
        set_modes(1'b0, 1'b0);
        send_vector(4);
        set_modes(1'b1, 1'b1);
        send_vector(10);
        set_modes(1'b0, 1'b1);
        send_vector(3);
    endtask

    task automatic test_random_vectors(logic rel, logic pcm, int items);
        int sent;
        int len;
        set_modes(rel, pcm);
        sent = 0;
        while (sent < items)
        begin
            src_idle_en = $urandom_range(0, 3) != 0;
            snk_idle_en = $urandom_range(0, 3) != 0;
            case ($urandom_range(0, 3))
                0: len = CPS * $urandom_range(1, 3);
                1: len = $urandom_range(1, 4);
                default: len = $urandom_range(1, 30);
            endcase
            send_vector(len);
            sent += len;
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = REG_RELATIVE;
        cfg_data = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tlast = 1'b0;
        errors = 0;
        cycles = 0;
        send_gap = 0;
        src_idle_en = 1'b1;
        snk_idle_en = 1'b1;
        p_rel = 1'b0;
        p_pcm = 1'b0;
        p_sig_norm = 0;
        p_ref_norm = 0;
        p_idx = 0;
        clear_accumulators();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_plain_norms();
        test_component_tracking();
        test_ratios();
        test_mode_change_mid_vector();
        test_random_vectors(1'b0, 1'b0, 180);
        test_random_vectors(1'b1, 1'b0, 180);
        test_random_vectors(1'b0, 1'b1, 180);
        test_random_vectors(1'b1, 1'b1, 180);

        wait_idle();
        if (errors == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end
endmodule

>>> squared_norm_min_max_reduce.f
rtl/snmr_pkg.sv
rtl/snmr_div.sv
rtl/snmr_ctrl.sv
rtl/snmr_dp.sv
rtl/squared_norm_min_max_reduce.sv
tb/sv/tb.sv
